// ===== hdl/motion_step_fall_detector_core_assert.svh =====
// assertion macros used by the motion step / fall detector tracker
// each macro expects clk and rst_n in scope
`ifndef MOTION_STEP_FALL_DETECTOR_CORE_ASSERT_SVH
`define MOTION_STEP_FALL_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define MSFD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msfd assertion failed");

// next-cycle implication
`define MSFD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msfd assertion failed");

`endif

// ===== hdl/msfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfd_pkg
// Types and constants shared by the motion step / fall detector modules.
// ----------------------------------------------------------------------------
package msfd_pkg;

    // field widths
    localparam int ACC_W   = 14;
    localparam int TIME_W  = 32;
    localparam int MG_W    = 13;
    localparam int MS16_W  = 16;
    localparam int SQR_W   = 27;   // one squared axis, up to 2^26
    localparam int M2_W    = 28;   // sum of three squares
    localparam int HI_W    = 14;   // 1 g plus threshold
    localparam int LO_W    = 10;   // 1 g minus threshold
    localparam int THSQ_W  = 26;   // squared 13-bit threshold
    localparam int IN_W    = 80;
    localparam int OUT_W   = 40;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [HI_W-1:0] ONE_G_MG = 14'd1000;

    // register indexes
    localparam logic [2:0] REG_MOVE_TH   = 3'd0;
    localparam logic [2:0] REG_STEP_TH   = 3'd1;
    localparam logic [2:0] REG_STEP_DEB  = 3'd2;
    localparam logic [2:0] REG_FF_TH     = 3'd3;
    localparam logic [2:0] REG_IMPACT_TH = 3'd4;
    localparam logic [2:0] REG_FALL_WIN  = 3'd5;
    localparam logic [2:0] REG_ALERT_MS  = 3'd6;

    // reset values
    localparam logic [MG_W-1:0]   RST_MOVE_TH   = 13'd100;
    localparam logic [MG_W-1:0]   RST_STEP_TH   = 13'd1200;
    localparam logic [MS16_W-1:0] RST_STEP_DEB  = 16'd300;
    localparam logic [MG_W-1:0]   RST_FF_TH     = 13'd400;
    localparam logic [MG_W-1:0]   RST_IMPACT_TH = 13'd2500;
    localparam logic [MS16_W-1:0] RST_FALL_WIN  = 16'd1000;
    localparam logic [TIME_W-1:0] RST_ALERT_MS  = 32'd30000;

    // timing settings used by the tracker
    typedef struct packed {
        logic [MS16_W-1:0] step_debounce_ms;
        logic [MS16_W-1:0] fall_window_ms;
        logic [TIME_W-1:0] fall_alert_ms;
    } msfd_cfg_t;

    // squared thresholds used by the datapath
    typedef struct packed {
        logic [M2_W-1:0]   move_hi_sq;
        logic [2*LO_W-1:0] move_lo_sq;
        logic              move_lo_en;
        logic [THSQ_W-1:0] step_sq;
        logic [THSQ_W-1:0] ff_sq;
        logic [THSQ_W-1:0] impact_sq;
    } msfd_sq_t;

    // per-sample level flags
    typedef struct packed {
        logic moving;
        logic above_step;
        logic free_fall;
        logic impact;
    } msfd_flags_t;

endpackage

// ===== hdl/msfd_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfd_regs
// Configuration registers on the APB port, plus squared thresholds.
// ----------------------------------------------------------------------------
module msfd_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [msfd_pkg::DATA_W-1:0]  pwdata,
    output logic [msfd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output msfd_pkg::msfd_cfg_t          cfg,
    output msfd_pkg::msfd_sq_t           sq
);
    import msfd_pkg::*;

    logic [MG_W-1:0]   move_th_reg;
    logic [MG_W-1:0]   step_th_reg;
    logic [MS16_W-1:0] step_deb_reg;
    logic [MG_W-1:0]   ff_th_reg;
    logic [MG_W-1:0]   impact_th_reg;
    logic [MS16_W-1:0] fall_win_reg;
    logic [TIME_W-1:0] alert_ms_reg;
    logic [2:0]        reg_idx;
    logic              wr_en;
    logic [HI_W-1:0]   move_hi;
    logic [LO_W-1:0]   move_lo;
    msfd_sq_t          sq_reg;
    msfd_sq_t          sq_next;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_th_reg   <= RST_MOVE_TH;
            step_th_reg   <= RST_STEP_TH;
            step_deb_reg  <= RST_STEP_DEB;
            ff_th_reg     <= RST_FF_TH;
            impact_th_reg <= RST_IMPACT_TH;
            fall_win_reg  <= RST_FALL_WIN;
            alert_ms_reg  <= RST_ALERT_MS;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MOVE_TH:   move_th_reg   <= pwdata[MG_W-1:0];
                REG_STEP_TH:   step_th_reg   <= pwdata[MG_W-1:0];
                REG_STEP_DEB:  step_deb_reg  <= pwdata[MS16_W-1:0];
                REG_FF_TH:     ff_th_reg     <= pwdata[MG_W-1:0];
                REG_IMPACT_TH: impact_th_reg <= pwdata[MG_W-1:0];
                REG_FALL_WIN:  fall_win_reg  <= pwdata[MS16_W-1:0];
                REG_ALERT_MS:  alert_ms_reg  <= pwdata;
                default:       ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_MOVE_TH:   prdata = {{(DATA_W-MG_W){1'b0}}, move_th_reg};
            REG_STEP_TH:   prdata = {{(DATA_W-MG_W){1'b0}}, step_th_reg};
            REG_STEP_DEB:  prdata = {{(DATA_W-MS16_W){1'b0}}, step_deb_reg};
            REG_FF_TH:     prdata = {{(DATA_W-MG_W){1'b0}}, ff_th_reg};
            REG_IMPACT_TH: prdata = {{(DATA_W-MG_W){1'b0}}, impact_th_reg};
            REG_FALL_WIN:  prdata = {{(DATA_W-MS16_W){1'b0}}, fall_win_reg};
            REG_ALERT_MS:  prdata = alert_ms_reg;
            default:       prdata = '0;
        endcase
    end

    // squared thresholds, one multiplier each, registered
    always_comb
    begin
        move_hi            = ONE_G_MG + {1'b0, move_th_reg};
        move_lo            = LO_W'(ONE_G_MG - {1'b0, move_th_reg});
        sq_next.move_hi_sq = M2_W'(move_hi) * M2_W'(move_hi);
        sq_next.move_lo_sq = move_lo * move_lo;
        sq_next.move_lo_en = ({1'b0, move_th_reg} < ONE_G_MG);
        sq_next.step_sq    = step_th_reg * step_th_reg;
        sq_next.ff_sq      = ff_th_reg * ff_th_reg;
        sq_next.impact_sq  = impact_th_reg * impact_th_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign sq = sq_reg;

    assign cfg.step_debounce_ms = step_deb_reg;
    assign cfg.fall_window_ms   = fall_win_reg;
    assign cfg.fall_alert_ms    = alert_ms_reg;

endmodule

// ===== hdl/msfd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfd_datapath
// Input register, squares, magnitude sum and threshold compares.
// ----------------------------------------------------------------------------
module msfd_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [msfd_pkg::IN_W-1:0]    in_data,
    input  msfd_pkg::msfd_sq_t           sq,
    output logic                         d_valid,
    output msfd_pkg::msfd_flags_t        d_flags,
    output logic [msfd_pkg::TIME_W-1:0]  d_time
);
    import msfd_pkg::*;

    logic                     a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic signed [ACC_W-1:0]  ax_reg, ay_reg, az_reg;
    logic [TIME_W-1:0]        a_time_reg, b_time_reg, c_time_reg, d_time_reg;
    logic [SQR_W-1:0]         bx_reg, by_reg, bz_reg;
    logic [SQR_W-1:0]         bx_next, by_next, bz_next;
    logic [M2_W-1:0]          m2_reg;
    logic [M2_W-1:0]          m2_next;
    msfd_flags_t              flags_reg;
    msfd_flags_t              flags_next;

    // stage valids, whole pipe moves together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // squares of each axis, operands sign-extended to the square width
    always_comb
    begin
        bx_next = SQR_W'(ax_reg) * SQR_W'(ax_reg);
        by_next = SQR_W'(ay_reg) * SQR_W'(ay_reg);
        bz_next = SQR_W'(az_reg) * SQR_W'(az_reg);
        m2_next = M2_W'(bx_reg) + M2_W'(by_reg) + M2_W'(bz_reg);
    end

    // threshold compares on the squared magnitude
    always_comb
    begin
        flags_next.moving     = (m2_reg > sq.move_hi_sq) ||
                                (sq.move_lo_en && (m2_reg < M2_W'(sq.move_lo_sq)));
        flags_next.above_step = m2_reg > M2_W'(sq.step_sq);
        flags_next.free_fall  = m2_reg < M2_W'(sq.ff_sq);
        flags_next.impact     = m2_reg > M2_W'(sq.impact_sq);
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg     <= in_data[ACC_W-1:0];
            ay_reg     <= in_data[2*ACC_W-1:ACC_W];
            az_reg     <= in_data[3*ACC_W-1:2*ACC_W];
            a_time_reg <= in_data[3*ACC_W+TIME_W-1:3*ACC_W];
            bx_reg     <= bx_next;
            by_reg     <= by_next;
            bz_reg     <= bz_next;
            b_time_reg <= a_time_reg;
            m2_reg     <= m2_next;
            c_time_reg <= b_time_reg;
            flags_reg  <= flags_next;
            d_time_reg <= c_time_reg;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_flags = flags_reg;
    assign d_time  = d_time_reg;

endmodule

// ===== hdl/msfd_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfd_tracker
// Step, fall and alert state, and the output register.
// ----------------------------------------------------------------------------
module msfd_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         d_valid,
    input  msfd_pkg::msfd_flags_t        d_flags,
    input  logic [msfd_pkg::TIME_W-1:0]  d_time,
    input  msfd_pkg::msfd_cfg_t          cfg,
    input  logic                         m_axis_tready,
    output logic                         m_axis_tvalid,
    output logic [msfd_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                         adv
);
    import msfd_pkg::*;

    logic              was_above_reg, was_above_next;
    logic [TIME_W-1:0] last_step_reg, last_step_next;
    logic [TIME_W-1:0] step_total_reg, step_total_next;
    logic              fall_armed_reg, fall_armed_next;
    logic [TIME_W-1:0] ff_time_reg, ff_time_next;
    logic              alert_active_reg, alert_active_next;
    logic [TIME_W-1:0] alert_time_reg, alert_time_next;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    logic              step_hit;
    logic              fall_hit;
    logic              take;

    // pipe moves when the output slot is free or being drained
    assign adv  = !out_valid_reg || m_axis_tready;
    assign take = adv && d_valid;

    // per-sample state update
    always_comb
    begin
        step_hit = d_flags.above_step && !was_above_reg &&
                   ((d_time - last_step_reg) >= TIME_W'(cfg.step_debounce_ms));
        step_total_next = step_hit ? step_total_reg + 1'b1 : step_total_reg;
        last_step_next  = step_hit ? d_time : last_step_reg;
        was_above_next  = d_flags.above_step;

        // free fall arms the candidate
        fall_armed_next = fall_armed_reg || d_flags.free_fall;
        ff_time_next    = d_flags.free_fall ? d_time : ff_time_reg;

        // impact inside the window confirms it
        fall_hit = fall_armed_next && d_flags.impact &&
                   ((d_time - ff_time_next) <= TIME_W'(cfg.fall_window_ms));
        alert_active_next = alert_active_reg;
        alert_time_next   = alert_time_reg;
        if (fall_hit)
        begin
            alert_active_next = 1'b1;
            alert_time_next   = d_time;
            fall_armed_next   = 1'b0;
        end

        // alert expiry
        if (alert_active_next && ((d_time - alert_time_next) > cfg.fall_alert_ms))
        begin
            alert_active_next = 1'b0;
        end

        out_data_next = {{(OUT_W-TIME_W-2){1'b0}}, alert_active_next,
                         step_total_next, d_flags.moving};
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_above_reg    <= 1'b0;
            last_step_reg    <= '0;
            step_total_reg   <= '0;
            fall_armed_reg   <= 1'b0;
            ff_time_reg      <= '0;
            alert_active_reg <= 1'b0;
            alert_time_reg   <= '0;
        end
        else if (take)
        begin
            was_above_reg    <= was_above_next;
            last_step_reg    <= last_step_next;
            step_total_reg   <= step_total_next;
            fall_armed_reg   <= fall_armed_next;
            ff_time_reg      <= ff_time_next;
            alert_active_reg <= alert_active_next;
            alert_time_reg   <= alert_time_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`include "motion_step_fall_detector_core_assert.svh"

    // a sample below the step level never counts a step
    `MSFD_ASSERT_NXT(a_no_step_below, take && !d_flags.above_step, step_total_reg == $past(step_total_reg))
    // a raised alert always leaves the candidate disarmed
    `MSFD_ASSERT_IMP(a_alert_disarms, $rose(alert_active_reg), !fall_armed_reg)
    // state is frozen while the output is stalled
    `MSFD_ASSERT_NXT(a_stall_holds, !adv, $stable(step_total_reg) && $stable(alert_active_reg))

endmodule

// ===== hdl/motion_step_fall_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_step_fall_detector_core
// Accelerometer step counter, movement flag and fall detector.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  s_axis    | in  | accel_x/y/z_mg (14b signed each), time_ms (32b)
//  m_axis    | out | moving (1b), steps (32b), fall_alert (1b)
//  apb       | cfg | seven threshold and timing registers at 4*index
//
// one sample per cycle while m_axis does not stall; a request's result passes through
// the input reg, then squares, magnitude sum, compares, state and output register
// rst_n clears all tracker state and loads register defaults
// stalls on m_axis freeze the whole pipe; s_axis_tready follows the output slot
module motion_step_fall_detector_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // {time_ms[73:42], accel_z_mg[41:28], accel_y_mg[27:14], accel_x_mg[13:0]}
    input  logic [msfd_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // {fall_alert[33], steps[32:1], moving[0]}
    output logic [msfd_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [msfd_pkg::DATA_W-1:0]  pwdata,
    output logic [msfd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import msfd_pkg::*;

    msfd_cfg_t         cfg;
    msfd_sq_t          sq;
    msfd_flags_t       d_flags;
    logic              d_valid;
    logic [TIME_W-1:0] d_time;
    logic              adv;

    assign s_axis_tready = adv;

    msfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .sq      (sq)
    );

    msfd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .sq       (sq),
        .d_valid  (d_valid),
        .d_flags  (d_flags),
        .d_time   (d_time)
    );

    msfd_tracker u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .d_valid       (d_valid),
        .d_flags       (d_flags),
        .d_time        (d_time),
        .cfg           (cfg),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .adv           (adv)
    );

endmodule
